@@ hdl/bris_pkg.sv @@
// shared constants and field widths for the bilinear rgb image scaler
package bris_pkg;
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 24;
    localparam int STEP_W  = 26;
    localparam int SIZE_W  = 13;
    localparam int PROD_W  = COORD_W + STEP_W;
    localparam int NUM_CHAN = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd5;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [9:0]        src_width;
        logic [9:0]        src_height;
        logic [SIZE_W-1:0] dst_width;
        logic [SIZE_W-1:0] dst_height;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } t_cfg;
endpackage

@@ hdl/bilinear_rgb_image_scaler.sv @@
// top level of the bilinear rgb888 image scaler
// Requests enter on the slave stream: tuser low loads one source pixel into the frame store,
// tuser high asks for one destination pixel, which leaves on the master stream. One request
// is taken every cycle unless the request queue is full; the frame store is split into four
// banks by row and column parity, so all four neighbors are read in the same cycle. A load
// is visible to every compute request behind it. Configuration writes belong to idle
// periods. The frame store has no reset and a pixel must be loaded before it is read.
module bilinear_rgb_image_scaler #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int FRAC_BITS      = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bris_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bris_pkg::STEP_W-1:0]    i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // x_coord, y_coord, red_in, green_in, blue_in
    input  logic [47:0]                    i_s_axis_tdata,
    // operation
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // dest_col, dest_row, red_out, green_out, blue_out
    output logic [47:0]                    o_m_axis_tdata
);
    localparam int CW = (MAX_SRC_WIDTH  > 1) ? $clog2(MAX_SRC_WIDTH)  : 1;
    localparam int RW = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int EW = 1 + 2 * CW + 2 * RW + 2 * FRAC_BITS
                      + 2 * bris_pkg::COORD_W + bris_pkg::PIX_W;

    logic          push, full, pop, empty;
    logic [EW-1:0] f_entry, q_entry;
    logic [bris_pkg::COORD_W-1:0] col, row;
    logic [bris_pkg::PIX_W-1:0]   rgb;

    bris_front #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .FRAC_BITS(FRAC_BITS), .CW(CW), .RW(RW), .EW(EW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_s_axis_tvalid), .o_ready(o_s_axis_tready),
        .i_op(i_s_axis_tuser),
        .i_x(i_s_axis_tdata[11:0]), .i_y(i_s_axis_tdata[23:12]),
        .i_rgb({i_s_axis_tdata[31:24], i_s_axis_tdata[39:32], i_s_axis_tdata[47:40]}),
        .o_push(push), .i_full(full), .o_entry(f_entry)
    );

    bris_queue #(.W(EW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(f_entry), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q_entry)
    );

    bris_back #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .FRAC_BITS(FRAC_BITS), .CW(CW), .RW(RW), .EW(EW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_entry(q_entry), .i_empty(empty), .o_pop(pop),
        .o_valid(o_m_axis_tvalid), .i_ready(i_m_axis_tready),
        .o_col(col), .o_row(row), .o_rgb(rgb)
    );

    assign o_m_axis_tdata = {rgb[7:0], rgb[15:8], rgb[23:16], row, col};
endmodule

@@ hdl/bris_front.sv @@
// front end: configuration registers, coordinate mapping, edge clamping, classification
module bris_front #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int FRAC_BITS      = 16,
    parameter int CW = 9,
    parameter int RW = 9,
    parameter int EW = 101
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bris_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bris_pkg::STEP_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [bris_pkg::COORD_W-1:0]  i_x,
    input  logic [bris_pkg::COORD_W-1:0]  i_y,
    input  logic [bris_pkg::PIX_W-1:0]    i_rgb,
    output logic                          o_push,
    input  logic                          i_full,
    output logic [EW-1:0]                 o_entry
);
    localparam int IXW = bris_pkg::PROD_W - FRAC_BITS;
    localparam logic [bris_pkg::SIZE_W-1:0] MAXW = bris_pkg::SIZE_W'(MAX_SRC_WIDTH);
    localparam logic [bris_pkg::SIZE_W-1:0] MAXH = bris_pkg::SIZE_W'(MAX_SRC_HEIGHT);

    bris_pkg::t_cfg r_cfg;

    logic [bris_pkg::SIZE_W-1:0] w_eff, h_eff, w_last, h_last, sw_ext, sh_ext;
    logic adv, accept, n_keep;

    logic                          r_f1_v, r_f1_op, r_f1_keep;
    logic [bris_pkg::COORD_W-1:0]  r_f1_x, r_f1_y;
    logic [bris_pkg::PIX_W-1:0]    r_f1_rgb;
    logic [bris_pkg::PROD_W-1:0]   r_f1_px, r_f1_py;

    logic          r_f2_v;
    logic [EW-1:0] r_f2_entry, n_entry;

    logic [IXW-1:0] ix, iy, wl, hl;
    logic [CW-1:0]  x0, x1;
    logic [RW-1:0]  y0, y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= 10'd512;
            r_cfg.src_height <= 10'd512;
            r_cfg.dst_width  <= 13'd512;
            r_cfg.dst_height <= 13'd512;
            r_cfg.x_step     <= 26'd65536;
            r_cfg.y_step     <= 26'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bris_pkg::CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[9:0];
                bris_pkg::CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[9:0];
                bris_pkg::CFG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[12:0];
                bris_pkg::CFG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[12:0];
                bris_pkg::CFG_X_STEP:     r_cfg.x_step     <= i_cfg_data;
                bris_pkg::CFG_Y_STEP:     r_cfg.y_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sw_ext = {3'b000, r_cfg.src_width};
        sh_ext = {3'b000, r_cfg.src_height};
        w_eff  = (sw_ext == '0) ? 13'd1 : ((sw_ext > MAXW) ? MAXW : sw_ext);
        h_eff  = (sh_ext == '0) ? 13'd1 : ((sh_ext > MAXH) ? MAXH : sh_ext);
        w_last = w_eff - 13'd1;
        h_last = h_eff - 13'd1;
    end

    assign adv     = !r_f2_v || !i_full;
    assign o_ready = adv;
    assign accept  = i_valid && adv;
    assign o_push  = r_f2_v && !i_full;
    assign o_entry = r_f2_entry;

    always_comb begin
        if (i_op == bris_pkg::OP_LOAD) begin
            n_keep = ({1'b0, i_x} < w_eff) && ({1'b0, i_y} < h_eff);
        end else begin
            n_keep = ({1'b0, i_x} < r_cfg.dst_width) && ({1'b0, i_y} < r_cfg.dst_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (adv) begin
            r_f1_v <= accept;
            r_f2_v <= r_f1_v && r_f1_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_op    <= i_op;
            r_f1_keep  <= n_keep;
            r_f1_x     <= i_x;
            r_f1_y     <= i_y;
            r_f1_rgb   <= i_rgb;
            r_f1_px    <= bris_pkg::PROD_W'(i_x) * bris_pkg::PROD_W'(r_cfg.x_step);
            r_f1_py    <= bris_pkg::PROD_W'(i_y) * bris_pkg::PROD_W'(r_cfg.y_step);
            r_f2_entry <= n_entry;
        end
    end

    always_comb begin
        ix = r_f1_px[bris_pkg::PROD_W-1:FRAC_BITS];
        iy = r_f1_py[bris_pkg::PROD_W-1:FRAC_BITS];
        wl = IXW'(w_last);
        hl = IXW'(h_last);
        if (r_f1_op == bris_pkg::OP_LOAD) begin
            x0 = r_f1_x[CW-1:0];
            x1 = r_f1_x[CW-1:0];
            y0 = r_f1_y[RW-1:0];
            y1 = r_f1_y[RW-1:0];
        end else begin
            x0 = (ix > wl)  ? wl[CW-1:0] : ix[CW-1:0];
            x1 = (ix >= wl) ? wl[CW-1:0] : CW'(ix + IXW'(1));
            y0 = (iy > hl)  ? hl[RW-1:0] : iy[RW-1:0];
            y1 = (iy >= hl) ? hl[RW-1:0] : RW'(iy + IXW'(1));
        end
        n_entry = {r_f1_op, x0, x1, y0, y1,
                   r_f1_px[FRAC_BITS-1:0], r_f1_py[FRAC_BITS-1:0],
                   r_f1_x, r_f1_y, r_f1_rgb};
    end
endmodule

@@ hdl/bris_queue.sv @@
// four-entry request queue between front and back
module bris_queue #(
    parameter int W = 101
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end
endmodule

@@ hdl/bris_back.sv @@
// back end: parity-banked frame store, neighbor fetch and bilinear interpolation pipeline
module bris_back #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int FRAC_BITS      = 16,
    parameter int CW = 9,
    parameter int RW = 9,
    parameter int EW = 101
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [EW-1:0]                i_entry,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bris_pkg::COORD_W-1:0] o_col,
    output logic [bris_pkg::COORD_W-1:0] o_row,
    output logic [bris_pkg::PIX_W-1:0]   o_rgb
);
    localparam int HW = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HH = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int HD = HW * HH;
    localparam int AW = (HD > 1) ? $clog2(HD) : 1;
    localparam int F  = FRAC_BITS;
    localparam int TW = F + 10;
    localparam int VW = 2 * F + 12;
    localparam int CH = bris_pkg::CHAN_W;

    logic                        e_op;
    logic [CW-1:0]               e_x0, e_x1;
    logic [RW-1:0]               e_y0, e_y1;
    logic [F-1:0]                e_fx, e_fy;
    logic [bris_pkg::COORD_W-1:0] e_col, e_row;
    logic [bris_pkg::PIX_W-1:0]  e_rgb;

    assign {e_op, e_x0, e_x1, e_y0, e_y1, e_fx, e_fy, e_col, e_row, e_rgb} = i_entry;

    logic adv, pop;
    assign adv   = !o_valid || i_ready;
    assign pop   = adv && !i_empty;
    assign o_pop = pop;

    logic [bris_pkg::PIX_W-1:0] r_rd [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [bris_pkg::PIX_W-1:0] mem [HD];
        logic [CW-1:0] csel;
        logic [RW-1:0] rsel;
        logic [AW-1:0] addr;
        always_comb begin
            csel = (e_x0[0] == b[0]) ? e_x0 : e_x1;
            rsel = (e_y0[0] == b[1]) ? e_y0 : e_y1;
            addr = AW'((32'(rsel) >> 1) * HW + (32'(csel) >> 1));
        end
        always_ff @(posedge i_clk) begin
            if (pop) begin
                if (e_op == bris_pkg::OP_LOAD) begin
                    if ({e_y0[0], e_x0[0]} == 2'(b)) mem[addr] <= e_rgb;
                end else begin
                    r_rd[b] <= mem[addr];
                end
            end
        end
    end

    logic                         r_b1_v, r_b2_v, r_b3_v, r_ov;
    logic [F-1:0]                 r_b1_fx, r_b1_fy, r_b2_fy;
    logic [1:0]                   r_nw, r_ne, r_sw, r_se;
    logic [bris_pkg::COORD_W-1:0] r_b1_col, r_b1_row, r_b2_col, r_b2_row;
    logic [bris_pkg::COORD_W-1:0] r_b3_col, r_b3_row;
    logic signed [TW-1:0]         r_top [bris_pkg::NUM_CHAN];
    logic signed [TW-1:0]         r_bot [bris_pkg::NUM_CHAN];
    logic signed [VW-1:0]         r_v   [bris_pkg::NUM_CHAN];
    logic signed [TW-1:0]         n_top [bris_pkg::NUM_CHAN];
    logic signed [TW-1:0]         n_bot [bris_pkg::NUM_CHAN];
    logic signed [VW-1:0]         n_v   [bris_pkg::NUM_CHAN];
    logic [bris_pkg::PIX_W-1:0]   n_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (adv) begin
            r_b1_v <= pop && (e_op == bris_pkg::OP_COMPUTE);
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_ov   <= r_b3_v;
        end
    end

    always_comb begin
        logic [CH-1:0] nw, ne, sw, se;
        logic signed [TW:0] d;
        for (int c = 0; c < bris_pkg::NUM_CHAN; c++) begin
            nw = r_rd[r_nw][23-8*c -: 8];
            ne = r_rd[r_ne][23-8*c -: 8];
            sw = r_rd[r_sw][23-8*c -: 8];
            se = r_rd[r_se][23-8*c -: 8];
            n_top[c] = $signed(TW'({nw, F'(0)}))
                     + TW'($signed({1'b0, r_b1_fx}) * ($signed({1'b0, ne}) - $signed({1'b0, nw})));
            n_bot[c] = $signed(TW'({sw, F'(0)}))
                     + TW'($signed({1'b0, r_b1_fx}) * ($signed({1'b0, se}) - $signed({1'b0, sw})));
            d = (TW+1)'(r_bot[c]) - (TW+1)'(r_top[c]);
            n_v[c] = ($signed(VW'(r_top[c])) <<< F) + VW'($signed({1'b0, r_b2_fy}) * d);
        end
    end

    always_comb begin
        for (int c = 0; c < bris_pkg::NUM_CHAN; c++) begin
            if (r_v[c][VW-1]) begin
                n_rgb[23-8*c -: 8] = '0;
            end else if (|r_v[c][VW-2:2*F+8]) begin
                n_rgb[23-8*c -: 8] = bris_pkg::CHAN_MAX;
            end else begin
                n_rgb[23-8*c -: 8] = r_v[c][2*F+7:2*F];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (pop) begin
                r_b1_fx  <= e_fx;
                r_b1_fy  <= e_fy;
                r_b1_col <= e_col;
                r_b1_row <= e_row;
                r_nw     <= {e_y0[0], e_x0[0]};
                r_ne     <= {e_y0[0], e_x1[0]};
                r_sw     <= {e_y1[0], e_x0[0]};
                r_se     <= {e_y1[0], e_x1[0]};
            end
            r_b2_fy  <= r_b1_fy;
            r_b2_col <= r_b1_col;
            r_b2_row <= r_b1_row;
            r_b3_col <= r_b2_col;
            r_b3_row <= r_b2_row;
            o_col    <= r_b3_col;
            o_row    <= r_b3_row;
            o_rgb    <= n_rgb;
            for (int c = 0; c < bris_pkg::NUM_CHAN; c++) begin
                r_top[c] <= n_top[c];
                r_bot[c] <= n_bot[c];
                r_v[c]   <= n_v[c];
            end
        end
    end

    assign o_valid = r_ov;
endmodule
